// File: rtl/core/tmsg_pkg.sv
// Shared types, codes and constants of the touch-mode sequencer with grumble gate.
// No dependencies; every other file of the block refers to this package by scoped names.
package tmsg_pkg;

  // Field widths
  localparam int unsigned OpW    = 3;
  localparam int unsigned TickW  = 32;
  localparam int unsigned AssetW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned PctW   = 7;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned DelayW = 13;
  localparam int unsigned FadeW  = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Constants
  localparam logic [PctW-1:0]   PctFull     = 7'd100;
  localparam logic [DelayW-1:0] PostDelayMs = 13'd5000;
  localparam logic [FadeW-1:0]  FadeMs      = 10'd1000;
  localparam logic [CountW-1:0] CountMax    = 16'hFFFF;

  // Defaults for the top-level parameters
  localparam bit                GrumbleOnDefault     = 1'b1;
  localparam logic [AssetW-1:0] TrackOneAssetDefault = 32'd1;

  // Event opcodes
  typedef enum logic [OpW-1:0] {
    OP_TOUCH_DOWN = 3'd0,
    OP_HOLD       = 3'd1,
    OP_AUDIO_DONE = 3'd2,
    OP_TIMER      = 3'd3,
    OP_AUDIO_ERR  = 3'd4,
    OP_RESET_FLOW = 3'd5,
    OP_OTHER      = 3'd6
  } op_e;

  // Action codes
  typedef enum logic [CodeW-1:0] {
    ACT_NONE           = 3'd0,
    ACT_PLAY_GRUMBLE   = 3'd1,
    ACT_START_SEQUENCE = 3'd2,
    ACT_BEGIN_COOLDOWN = 3'd3,
    ACT_FADE_OUT       = 3'd4,
    ACT_RETURN_IDLE    = 3'd5
  } act_e;

  // Scene codes
  typedef enum logic [CodeW-1:0] {
    SCENE_NONE       = 3'd0,
    SCENE_IDLE       = 3'd1,
    SCENE_GRUMBLE    = 3'd2,
    SCENE_ACTIVATING = 3'd3,
    SCENE_AURA       = 3'd4
  } scene_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BURST_FLOOR     = 3'd0,
    CFG_BURST_GAP       = 3'd1,
    CFG_COOLDOWN_TICKS  = 3'd2,
    CFG_BASE_PCT        = 3'd3,
    CFG_STEP_PCT        = 3'd4,
    CFG_MAX_PCT         = 3'd5,
    CFG_GRUMBLE_ASSET   = 3'd6,
    CFG_TRACK_TWO_ASSET = 3'd7
  } cfg_idx_e;

  // Register file contents
  typedef struct packed {
    logic [CountW-1:0] burst_floor;
    logic [TickW-1:0]  burst_gap;
    logic [TickW-1:0]  cooldown_ticks;
    logic [PctW-1:0]   base_pct;
    logic [PctW-1:0]   step_pct;
    logic [PctW-1:0]   max_pct;
    logic [AssetW-1:0] grumble_asset;
    logic [AssetW-1:0] track_two_asset;
  } cfg_t;

  // Registered event, with the random word already reduced to a roll in 0..99
  typedef struct packed {
    op_e               opcode;
    logic [TickW-1:0]  now_tick;
    logic [AssetW-1:0] event_value;
    logic [PctW-1:0]   roll;
  } evt_t;

endpackage

// File: rtl/core/tmsg_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// Depends on tmsg_pkg for field widths.
interface tmsg_evt_if;
  logic                        valid;
  logic                        ready;
  logic [tmsg_pkg::OpW-1:0]    opcode;
  logic [tmsg_pkg::TickW-1:0]  now_tick;
  logic [tmsg_pkg::AssetW-1:0] event_value;
  logic [31:0]                 random_word;

  modport source (output valid, opcode, now_tick, event_value, random_word, input ready);
  modport sink   (input valid, opcode, now_tick, event_value, random_word, output ready);
endinterface

interface tmsg_res_if;
  logic                        valid;
  logic                        ready;
  logic [tmsg_pkg::CodeW-1:0]  action_code;
  logic [tmsg_pkg::CodeW-1:0]  scene_code;
  logic [tmsg_pkg::AssetW-1:0] first_asset;
  logic [tmsg_pkg::AssetW-1:0] second_asset;
  logic [tmsg_pkg::DelayW-1:0] delay_ms;
  logic [tmsg_pkg::FadeW-1:0]  fade_ms;
  logic [tmsg_pkg::CodeW-1:0]  flow_now;

  modport source (output valid, action_code, scene_code, first_asset, second_asset,
                  delay_ms, fade_ms, flow_now, input ready);
  modport sink   (input valid, action_code, scene_code, first_asset, second_asset,
                  delay_ms, fade_ms, flow_now, output ready);
endinterface

// File: rtl/core/tmsg_cfg_regs.sv
// Configuration register file of the sequencer, written through a plain write port.
// Depends on tmsg_pkg.
module tmsg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tmsg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tmsg_pkg::CfgDataW-1:0] cfg_data_i,
  output tmsg_pkg::cfg_t                cfg_o
);

  tmsg_pkg::cfg_t cfg_q;

  // Write one register per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.burst_floor     <= 16'd3;
      cfg_q.burst_gap       <= 32'd6000;
      cfg_q.cooldown_ticks  <= 32'd20000;
      cfg_q.base_pct        <= 7'd15;
      cfg_q.step_pct        <= 7'd10;
      cfg_q.max_pct         <= 7'd65;
      cfg_q.grumble_asset   <= 32'd3;
      cfg_q.track_two_asset <= 32'd2;
    end else if (cfg_we_i) begin
      case (tmsg_pkg::cfg_idx_e'(cfg_idx_i))
        tmsg_pkg::CFG_BURST_FLOOR:     cfg_q.burst_floor     <= cfg_data_i[15:0];
        tmsg_pkg::CFG_BURST_GAP:       cfg_q.burst_gap       <= cfg_data_i;
        tmsg_pkg::CFG_COOLDOWN_TICKS:  cfg_q.cooldown_ticks  <= cfg_data_i;
        tmsg_pkg::CFG_BASE_PCT:        cfg_q.base_pct        <= cfg_data_i[6:0];
        tmsg_pkg::CFG_STEP_PCT:        cfg_q.step_pct        <= cfg_data_i[6:0];
        tmsg_pkg::CFG_MAX_PCT:         cfg_q.max_pct         <= cfg_data_i[6:0];
        tmsg_pkg::CFG_GRUMBLE_ASSET:   cfg_q.grumble_asset   <= cfg_data_i;
        tmsg_pkg::CFG_TRACK_TWO_ASSET: cfg_q.track_two_asset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/tmsg_in_stage.sv
// Input register of the sequencer: captures an event and reduces its random word mod 100.
// Depends on tmsg_pkg and tmsg_evt_if.
module tmsg_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  tmsg_evt_if.sink       evt_i,
  input  logic           take_i,
  output logic           valid_o,
  output tmsg_pkg::evt_t evt_o
);

  logic           valid_q;
  tmsg_pkg::evt_t evt_q;
  tmsg_pkg::evt_t evt_d;
  logic           accept;

  // Remainder by 100 via reciprocal multiply (exact for all 32-bit words)
  logic [63:0] recip_prod;
  logic [26:0] quot;
  logic [33:0] quot_x100;
  logic [31:0] rem;

  always_comb begin
    recip_prod = {32'd0, evt_i.random_word} * 64'h0000_0000_51EB_851F;
    quot       = recip_prod[63:37];
    quot_x100  = {7'd0, quot} * 34'd100;
    rem        = evt_i.random_word - quot_x100[31:0];
  end

  always_comb begin
    evt_d.opcode      = tmsg_pkg::op_e'(evt_i.opcode);
    evt_d.now_tick    = evt_i.now_tick;
    evt_d.event_value = evt_i.event_value;
    evt_d.roll        = rem[6:0];
  end

  // Open for a new item when empty or when the held item moves on
  assign evt_i.ready = !valid_q || take_i;
  assign accept      = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      valid_q <= evt_i.valid;
    end
  end

  // Hold payload until the next accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      evt_q <= evt_d;
    end
  end

  assign valid_o = valid_q;
  assign evt_o   = evt_q;

endmodule

// File: rtl/core/tmsg_flow.sv
// Flow state machine, burst counter and grumble gate, with the result register.
// Depends on tmsg_pkg and tmsg_res_if.
module tmsg_flow #(
  parameter bit                                GrumbleOn     = tmsg_pkg::GrumbleOnDefault,
  parameter logic [tmsg_pkg::AssetW-1:0]       TrackOneAsset = tmsg_pkg::TrackOneAssetDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tmsg_pkg::cfg_t cfg_i,
  input  logic           valid_i,
  input  tmsg_pkg::evt_t evt_i,
  output logic           take_o,
  tmsg_res_if.source     res_o
);

  typedef enum logic [tmsg_pkg::CodeW-1:0] {
    FLOW_IDLE    = 3'd0,
    FLOW_GRUMBLE = 3'd1,
    FLOW_SEQ     = 3'd2,
    FLOW_POST    = 3'd3,
    FLOW_FADE    = 3'd4
  } flow_e;

  flow_e                       flow_q, flow_d;
  logic [tmsg_pkg::TickW-1:0]  last_touch_q, last_touch_d;
  logic [tmsg_pkg::TickW-1:0]  cool_until_q, cool_until_d;
  logic [tmsg_pkg::CountW-1:0] count_q, count_d;

  logic                        out_valid_q;
  tmsg_pkg::act_e              act_q, act_d;
  tmsg_pkg::scene_e            scene_q, scene_d;
  logic [tmsg_pkg::AssetW-1:0] first_q, first_d;
  logic [tmsg_pkg::AssetW-1:0] second_q, second_d;
  logic [tmsg_pkg::DelayW-1:0] delay_q, delay_d;
  logic [tmsg_pkg::FadeW-1:0]  fade_q, fade_d;

  // Gate terms
  logic [tmsg_pkg::TickW-1:0]  win, cool, win_end, win_diff, cool_diff;
  logic                        restart, cool_ok;
  logic [tmsg_pkg::CountW-1:0] cnt_base, cnt_next, cnt_over;
  logic [22:0]                 chance_prod;
  logic [23:0]                 chance_sum;
  logic [tmsg_pkg::PctW-1:0]   chance;
  logic                        fire;

  // Move the item on when the result register is free or being drained
  assign take_o = valid_i && (!out_valid_q || res_o.ready);

  // Burst count update and grumble roll
  always_comb begin
    win       = (cfg_i.burst_gap == '0) ? 32'd1 : cfg_i.burst_gap;
    cool      = (cfg_i.cooldown_ticks == '0) ? 32'd1 : cfg_i.cooldown_ticks;
    win_end   = last_touch_q + win;
    win_diff  = evt_i.now_tick - win_end;
    restart   = (last_touch_q != '0) && !win_diff[31];
    cnt_base  = restart ? '0 : count_q;
    cnt_next  = (cnt_base < tmsg_pkg::CountMax) ? cnt_base + 16'd1 : cnt_base;
    cool_diff = evt_i.now_tick - cool_until_q;
    cool_ok   = !cool_diff[31];
    cnt_over  = cnt_next - cfg_i.burst_floor;
    chance_prod = {7'd0, cnt_over} * {16'd0, cfg_i.step_pct};
    chance_sum  = {17'd0, cfg_i.base_pct} + {1'b0, chance_prod};
    // Cap at max_pct, then at full percent
    if (chance_sum > {17'd0, cfg_i.max_pct}) begin
      chance = cfg_i.max_pct;
    end else begin
      chance = chance_sum[6:0];
    end
    if (chance > tmsg_pkg::PctFull) begin
      chance = tmsg_pkg::PctFull;
    end
    fire = cool_ok && (cnt_next >= cfg_i.burst_floor) && (evt_i.roll < chance);
  end

  // Next state and result for the held item
  always_comb begin
    flow_d       = flow_q;
    last_touch_d = last_touch_q;
    cool_until_d = cool_until_q;
    count_d      = count_q;
    act_d        = tmsg_pkg::ACT_NONE;
    scene_d      = tmsg_pkg::SCENE_NONE;
    first_d      = '0;
    second_d     = '0;
    delay_d      = '0;
    fade_d       = '0;
    case (evt_i.opcode)
      tmsg_pkg::OP_TOUCH_DOWN: begin
        if (GrumbleOn && flow_q == FLOW_IDLE) begin
          last_touch_d = evt_i.now_tick;
          count_d      = cnt_next;
          if (fire) begin
            cool_until_d = evt_i.now_tick + cool;
            count_d      = '0;
            act_d        = tmsg_pkg::ACT_PLAY_GRUMBLE;
            scene_d      = tmsg_pkg::SCENE_GRUMBLE;
            first_d      = cfg_i.grumble_asset;
            flow_d       = FLOW_GRUMBLE;
          end
        end
      end
      tmsg_pkg::OP_HOLD: begin
        if (flow_q == FLOW_IDLE || flow_q == FLOW_GRUMBLE) begin
          act_d    = tmsg_pkg::ACT_START_SEQUENCE;
          scene_d  = tmsg_pkg::SCENE_ACTIVATING;
          first_d  = TrackOneAsset;
          second_d = cfg_i.track_two_asset;
          flow_d   = FLOW_SEQ;
        end
      end
      tmsg_pkg::OP_AUDIO_DONE: begin
        if (flow_q == FLOW_GRUMBLE) begin
          if (evt_i.event_value == cfg_i.grumble_asset) begin
            flow_d = FLOW_IDLE;
          end
        end else if (flow_q == FLOW_SEQ && evt_i.event_value == cfg_i.track_two_asset) begin
          act_d   = tmsg_pkg::ACT_BEGIN_COOLDOWN;
          scene_d = tmsg_pkg::SCENE_AURA;
          delay_d = tmsg_pkg::PostDelayMs;
          flow_d  = FLOW_POST;
        end
      end
      tmsg_pkg::OP_TIMER: begin
        if (flow_q == FLOW_POST) begin
          act_d   = tmsg_pkg::ACT_FADE_OUT;
          fade_d  = tmsg_pkg::FadeMs;
          delay_d = {3'd0, tmsg_pkg::FadeMs};
          flow_d  = FLOW_FADE;
        end else if (flow_q == FLOW_FADE) begin
          act_d   = tmsg_pkg::ACT_RETURN_IDLE;
          scene_d = tmsg_pkg::SCENE_IDLE;
          flow_d  = FLOW_IDLE;
        end
      end
      tmsg_pkg::OP_AUDIO_ERR: begin
        act_d   = tmsg_pkg::ACT_RETURN_IDLE;
        scene_d = tmsg_pkg::SCENE_IDLE;
        flow_d  = FLOW_IDLE;
      end
      tmsg_pkg::OP_RESET_FLOW: begin
        flow_d       = FLOW_IDLE;
        last_touch_d = '0;
        cool_until_d = '0;
        count_d      = '0;
      end
      default: ;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q       <= FLOW_IDLE;
      last_touch_q <= '0;
      cool_until_q <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take_o) begin
        flow_q       <= flow_d;
        last_touch_q <= last_touch_d;
        cool_until_q <= cool_until_d;
        count_q      <= count_d;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each item taken
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      act_q    <= act_d;
      scene_q  <= scene_d;
      first_q  <= first_d;
      second_q <= second_d;
      delay_q  <= delay_d;
      fade_q   <= fade_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.action_code  = act_q;
  assign res_o.scene_code   = scene_q;
  assign res_o.first_asset  = first_q;
  assign res_o.second_asset = second_q;
  assign res_o.delay_ms     = delay_q;
  assign res_o.fade_ms      = fade_q;
  assign res_o.flow_now     = flow_q;

endmodule

// File: rtl/core/touch_mode_sequencer_with_grumble_gate.sv
// Top level of the touch-mode sequencer with grumble gate.
// Depends on tmsg_pkg, tmsg_if, tmsg_cfg_regs, tmsg_in_stage and tmsg_flow.
//
//   channel  dir  handshake      payload
//   evt_i    in   valid/ready    opcode, now_tick, event_value, random_word
//   res_o    out  valid/ready    action_code, scene_code, first_asset, second_asset,
//                                delay_ms, fade_ms, flow_now
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while res_o is ready; each event yields one result,
// registered in the input register, then by the flow logic in the result register.
// Reset (rst_ni low, asynchronous) empties both registers, returns the flow to
// idle, clears the burst state and loads the register defaults.
// A stalled result holds the result register; the input register still takes
// one more item, and input ready drops only while both registers are full.
module touch_mode_sequencer_with_grumble_gate #(
  parameter bit                          GrumbleOn     = tmsg_pkg::GrumbleOnDefault,
  parameter logic [tmsg_pkg::AssetW-1:0] TrackOneAsset = tmsg_pkg::TrackOneAssetDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tmsg_evt_if.sink                      evt_i,
  tmsg_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [tmsg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tmsg_pkg::CfgDataW-1:0] cfg_data_i
);

  tmsg_pkg::cfg_t cfg;
  tmsg_pkg::evt_t evt_held;
  logic           evt_held_valid;
  logic           take;

  tmsg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tmsg_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt_i),
    .take_i  (take),
    .valid_o (evt_held_valid),
    .evt_o   (evt_held)
  );

  tmsg_flow #(
    .GrumbleOn     (GrumbleOn),
    .TrackOneAsset (TrackOneAsset)
  ) u_flow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (evt_held_valid),
    .evt_i   (evt_held),
    .take_o  (take),
    .res_o   (res_o)
  );

endmodule
